// File: design/knph_pkg.sv
// Shared types and constants for the k nearest points heap.
package knph_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic KIND_OFFER = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef struct packed {
      logic [31:0]        sq_dist;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } point_type;

   typedef struct packed {
      logic      drain;
      point_type pt;
   } job_type;

endpackage

// File: design/knph_ram.sv
// Generic single write port, single read port RAM with registered read.
module knph_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/knph_front.sv
// Front stage: accept request transactions and compute squared distance.
module knph_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,   // [15:0] x_coord, [31:16] y_coord
   input  logic                      req_tuser,   // [0] kind
   output logic                      job_valid,
   input  logic                      job_ready,
   output knph_pkg::job_type         job
);

   logic               s_valid_ff, s_valid_in;
   logic               s_kind_ff;
   logic signed [15:0] s_x_ff;
   logic signed [15:0] s_y_ff;
   logic [31:0]        s_xx_ff;
   logic [31:0]        s_yy_ff;
   logic signed [15:0] in_x;
   logic signed [15:0] in_y;
   logic signed [31:0] xx_prod;
   logic signed [31:0] yy_prod;
   logic               advance;

   assign in_x    = req_tdata[15:0];
   assign in_y    = req_tdata[31:16];
   assign xx_prod = in_x * in_x;
   assign yy_prod = in_y * in_y;

   assign advance    = !s_valid_ff || job_ready;
   assign req_tready = advance;
   assign s_valid_in = advance ? req_tvalid : s_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         s_kind_ff <= req_tuser;
         s_x_ff    <= in_x;
         s_y_ff    <= in_y;
         s_xx_ff   <= unsigned'(xx_prod);
         s_yy_ff   <= unsigned'(yy_prod);
      end
   end

   assign job_valid      = s_valid_ff;
   assign job.drain      = s_kind_ff;
   assign job.pt.sq_dist = s_xx_ff + s_yy_ff;
   assign job.pt.x       = s_x_ff;
   assign job.pt.y       = s_y_ff;

endmodule

// File: design/knph_queue.sv
// Short job queue between the front stage and the heap engine.
module knph_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  knph_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output knph_pkg::job_type pop_job
);

   localparam int DEPTH = knph_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   knph_pkg::job_type slots [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != (PW + 1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = slots[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: design/knph_heap.sv
// Heap engine: bounded max-heap insert, replace and drain over a RAM.
module knph_heap #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(CAPACITY + 1)-1:0]     eff_k,
   input  logic                                job_valid,
   output logic                                job_ready,
   input  knph_pkg::job_type                   job,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [63:0]                         rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_APPEND = 3'd1;
   localparam logic [2:0] ST_SU     = 3'd2;
   localparam logic [2:0] ST_POP    = 3'd3;
   localparam logic [2:0] ST_SD_L   = 3'd4;
   localparam logic [2:0] ST_SD_R   = 3'd5;
   localparam logic [2:0] ST_FIN    = 3'd6;
   localparam logic [2:0] ST_EMIT   = 3'd7;

   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_REPLACE = 2'd1;
   localparam logic [1:0] MODE_DRAIN   = 2'd2;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic [CW-1:0]       held_ff, held_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                rvalid_ff, rvalid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_last_ff, rsp_last_in;
   knph_pkg::point_type rsp_pt_ff, rsp_pt_in;
   knph_pkg::point_type elem_ff, elem_in;
   knph_pkg::point_type new_ff, new_in;
   knph_pkg::point_type top_ff, top_in;
   knph_pkg::point_type lch_ff, lch_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   knph_pkg::point_type wr_data;
   logic [AW-1:0]       rd_addr;
   logic [63:0]         rd_raw;
   knph_pkg::point_type rd_pt;

   logic [2:0]          sd_done_state;
   logic [CW-1:0]       held_inc;
   logic [CW-1:0]       held_dec;
   logic [CW-1:0]       up_pos;
   logic                pick_l;
   logic                pick_r;
   logic [31:0]         cand_dist;
   logic [CW:0]         child_idx;
   logic [CW-1:0]       child_pos;
   logic                rsp_load_ok;

   function automatic logic [AW-1:0] slot_addr(input logic [CW:0] p);
      logic [CW:0] t;
      t = p - 1'b1;
      return t[AW-1:0];
   endfunction

   knph_ram #(
      .WIDTH (64),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_pt         = rd_raw;
   assign sd_done_state = (mode_ff == MODE_DRAIN) ? ST_EMIT : ST_APPEND;
   assign held_inc      = held_ff + 1'b1;
   assign held_dec      = held_ff - 1'b1;
   assign up_pos        = pos_ff >> 1;
   assign rsp_load_ok   = !rsp_valid_ff || rsp_tready;

   assign pick_l    = lch_ff.sq_dist > elem_ff.sq_dist;
   assign cand_dist = pick_l ? lch_ff.sq_dist : elem_ff.sq_dist;
   assign pick_r    = rvalid_ff && (rd_pt.sq_dist > cand_dist);
   assign child_idx = pick_r ? {pos_ff, 1'b1} : {pos_ff, 1'b0};
   assign child_pos = child_idx[CW-1:0];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      held_in      = held_ff;
      pos_in       = pos_ff;
      rvalid_in    = rvalid_ff;
      elem_in      = elem_ff;
      new_in       = new_ff;
      lch_in       = lch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pt_in    = rsp_pt_ff;
      rsp_last_in  = rsp_last_ff;
      job_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_addr({1'b0, pos_ff});
      wr_data      = elem_ff;
      rd_addr      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_ready = 1'b1;
               if (job.drain == knph_pkg::KIND_DRAIN) begin
                  mode_in  = MODE_DRAIN;
                  state_in = ST_EMIT;
               end else begin
                  new_in = job.pt;
                  if (held_ff >= eff_k) begin
                     if (top_ff.sq_dist > job.pt.sq_dist) begin
                        mode_in  = MODE_REPLACE;
                        rd_addr  = slot_addr({1'b0, held_ff});
                        state_in = ST_POP;
                     end
                  end else begin
                     mode_in  = MODE_INSERT;
                     state_in = ST_APPEND;
                  end
               end
            end
         end
         ST_APPEND: begin
            held_in = held_inc;
            elem_in = new_ff;
            mode_in = MODE_INSERT;
            if (held_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = new_ff;
               state_in = ST_IDLE;
            end else begin
               pos_in   = held_inc;
               rd_addr  = slot_addr({2'b00, held_inc[CW-1:1]});
               state_in = ST_SU;
            end
         end
         ST_SU: begin
            wr_en = 1'b1;
            if (elem_ff.sq_dist > rd_pt.sq_dist) begin
               wr_data = rd_pt;
               pos_in  = up_pos;
               if (up_pos > CW'(1)) begin
                  rd_addr = slot_addr({2'b00, up_pos[CW-1:1]});
               end else begin
                  state_in = ST_FIN;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            elem_in = rd_pt;
            held_in = held_dec;
            pos_in  = CW'(1);
            if ({1'b0, held_dec} >= (CW + 1)'(2)) begin
               rd_addr  = slot_addr((CW + 1)'(2));
               state_in = ST_SD_L;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = rd_pt;
               state_in = sd_done_state;
            end
         end
         ST_SD_L: begin
            lch_in    = rd_pt;
            rvalid_in = {pos_ff, 1'b1} <= {1'b0, held_ff};
            rd_addr   = slot_addr({pos_ff, 1'b1});
            state_in  = ST_SD_R;
         end
         ST_SD_R: begin
            wr_en = 1'b1;
            if (!pick_l && !pick_r) begin
               state_in = sd_done_state;
            end else begin
               wr_data = pick_r ? rd_pt : lch_ff;
               pos_in  = child_pos;
               if ({child_pos, 1'b0} <= {1'b0, held_ff}) begin
                  rd_addr  = slot_addr({child_pos, 1'b0});
                  state_in = ST_SD_L;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            wr_en    = 1'b1;
            state_in = (mode_ff == MODE_INSERT) ? ST_IDLE : sd_done_state;
         end
         ST_EMIT: begin
            if (held_ff == '0) begin
               state_in = ST_IDLE;
            end else if (rsp_load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_pt_in    = top_ff;
               rsp_last_in  = held_ff == CW'(1);
               rd_addr      = slot_addr({1'b0, held_ff});
               state_in     = ST_POP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign top_in = (wr_en && wr_addr == '0) ? wr_data : top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_INSERT;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      rvalid_ff   <= rvalid_in;
      elem_ff     <= elem_in;
      new_ff      <= new_in;
      top_ff      <= top_in;
      lch_ff      <= lch_in;
      rsp_pt_ff   <= rsp_pt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pt_ff.sq_dist, rsp_pt_ff.y, rsp_pt_ff.x};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: design/k_nearest_points_heap.sv
// Top level of the k nearest points heap: front stage, job queue, heap engine.
//
//   channel  direction  handshake          payload
//   req      in         tvalid / tready    tdata {y_coord, x_coord}, tuser kind
//   rsp      out        tvalid / tready    tdata {distance, y, x}, tlast last point
//   csr      in         csr_wr_en          csr_wr_data k_count
//
// An item passes the registered front stage and the queue; the engine takes it when idle.
// An insert adds the append state and, when the heap was not empty, climbs through the
// sift-up state level by level, ending in it or in the finish state. A replace first pops
// the top and sinks through the sift-down states, then appends like an insert; a drain
// emits and pops each point with the same sink. Reset empties the heap and sets k_count to 1.
// A stalled rsp holds its point and the engine; the front stage and queue fill, then stall.
module k_nearest_points_heap #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] x_coord, [31:16] y_coord
   input  logic        req_tuser,    // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [15:0] out_x, [31:16] out_y, [63:32] out_distance
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data   // [6:0] k_count
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [6:0]        k_count_ff, k_count_in;
   logic [6:0]        k_clamped;
   logic              fr_valid;
   logic              fr_ready;
   knph_pkg::job_type fr_job;
   logic              q_valid;
   logic              q_ready;
   knph_pkg::job_type q_job;

   assign k_count_in = csr_wr_en ? csr_wr_data : k_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_count_ff <= 7'd1;
      end else begin
         k_count_ff <= k_count_in;
      end
   end

   always_comb begin
      k_clamped = k_count_ff;
      if (k_count_ff == '0) begin
         k_clamped = 7'd1;
      end else if (k_count_ff > 7'(CAPACITY)) begin
         k_clamped = 7'(CAPACITY);
      end
   end

   knph_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (fr_valid),
      .job_ready  (fr_ready),
      .job        (fr_job)
   );

   knph_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_job   (fr_job),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_job    (q_job)
   );

   knph_heap #(
      .CAPACITY (CAPACITY)
   ) u_heap (
      .clock      (clock),
      .reset      (reset),
      .eff_k      (k_clamped[CW-1:0]),
      .job_valid  (q_valid),
      .job_ready  (q_ready),
      .job        (q_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: design/knph_checker.sv
// Port-level checks for the k nearest points heap, bound to the top level.
module knph_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic               in_drain_ff, in_drain_in;
   logic [31:0]        prev_dist_ff, prev_dist_in;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [31:0] xx;
   logic signed [31:0] yy;
   logic [31:0]        dist_sum;
   logic               rsp_take;

   assign out_x    = rsp_tdata[15:0];
   assign out_y    = rsp_tdata[31:16];
   assign xx       = out_x * out_x;
   assign yy       = out_y * out_y;
   assign dist_sum = unsigned'(xx) + unsigned'(yy);
   assign rsp_take = rsp_tvalid && rsp_tready;

   assign in_drain_in  = rsp_take ? !rsp_tlast : in_drain_ff;
   assign prev_dist_in = rsp_take ? rsp_tdata[63:32] : prev_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_drain_ff <= 1'b0;
      end else begin
         in_drain_ff <= in_drain_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_dist_ff <= prev_dist_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_dist_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:32] == dist_sum)
      else $error("emitted distance does not match coordinates");

   a_drain_order: assert property (@(posedge clock) disable iff (reset)
      in_drain_ff && rsp_tvalid |-> rsp_tdata[63:32] <= prev_dist_ff)
      else $error("drain order not descending");

endmodule

bind k_nearest_points_heap knph_checker u_knph_checker (.*);
